// File: rtl/mcpr_pkg.sv
`timescale 1ns / 1ps

package mcpr_pkg;

    // Fixed field widths
    localparam int WS_BITS      = 7;
    localparam int SLOT_BITS    = 6;
    localparam int OUTCOME_BITS = 2;

    localparam logic [WS_BITS-1:0] WS_RESET = 7'd64;

    // Result outcome codes
    localparam logic [OUTCOME_BITS-1:0] OUT_ACCESS   = 2'd0;
    localparam logic [OUTCOME_BITS-1:0] OUT_IGNORED  = 2'd1;
    localparam logic [OUTCOME_BITS-1:0] OUT_PLACED   = 2'd2;
    localparam logic [OUTCOME_BITS-1:0] OUT_REPLACED = 2'd3;

    // Microprogram step addresses
    typedef enum logic [3:0] {
        U_EMIT    = 4'd0,
        U_IDLE    = 4'd1,
        U_DISP    = 4'd2,
        U_ACC     = 4'd3,
        U_F_START = 4'd4,
        U_F_MOD   = 4'd5,
        U_P_SCAN  = 4'd6,
        U_P_NEXT  = 4'd7,
        U_R_INIT  = 4'd8,
        U_R_RD    = 4'd9,
        U_R_EV    = 4'd10,
        U_R_NEXT  = 4'd11,
        U_V_RD    = 4'd12,
        U_V_WR    = 4'd13
    } ustep_t;

    // Datapath actions
    typedef enum logic [3:0] {
        A_NONE,
        A_EMIT,
        A_LOAD,
        A_FRD_ASLOT,
        A_ACC_UPD,
        A_SCAN_HAND,
        A_SCAN_SUB,
        A_PLACE_STEP,
        A_ADVANCE,
        A_REP_INIT,
        A_FRD_SCAN,
        A_CLEAR_USED,
        A_PRD_SCAN,
        A_REPLACE
    } act_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NEVER,
        C_NO_IN,
        C_FAULT,
        C_SCAN_GE_N,
        C_SLOT_FREE,
        C_NOT_LAST,
        C_VICTIM,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t   act;
        cond_t  cond;
        ustep_t target;
    } ctrl_t;

    typedef struct packed {
        logic no_in;
        logic fault;
        logic scan_ge_n;
        logic slot_free;
        logic not_last;
        logic victim;
        logic out_busy;
    } cond_flags_t;

    // Control store: next = condition ? target : step + 1
    function automatic ctrl_t ucode(input ustep_t s);
        ctrl_t w;
        case (s)
            U_EMIT:    w = '{A_EMIT,       C_OUT_BUSY,  U_EMIT};
            U_IDLE:    w = '{A_LOAD,       C_NO_IN,     U_IDLE};
            U_DISP:    w = '{A_FRD_ASLOT,  C_FAULT,     U_F_START};
            U_ACC:     w = '{A_ACC_UPD,    C_ALWAYS,    U_EMIT};
            U_F_START: w = '{A_SCAN_HAND,  C_NEVER,     U_IDLE};
            U_F_MOD:   w = '{A_SCAN_SUB,   C_SCAN_GE_N, U_F_MOD};
            U_P_SCAN:  w = '{A_PLACE_STEP, C_SLOT_FREE, U_EMIT};
            U_P_NEXT:  w = '{A_ADVANCE,    C_NOT_LAST,  U_P_SCAN};
            U_R_INIT:  w = '{A_REP_INIT,   C_NEVER,     U_IDLE};
            U_R_RD:    w = '{A_FRD_SCAN,   C_NEVER,     U_IDLE};
            U_R_EV:    w = '{A_CLEAR_USED, C_VICTIM,    U_V_RD};
            U_R_NEXT:  w = '{A_ADVANCE,    C_ALWAYS,    U_R_RD};
            U_V_RD:    w = '{A_PRD_SCAN,   C_NEVER,     U_IDLE};
            U_V_WR:    w = '{A_REPLACE,    C_ALWAYS,    U_EMIT};
            default:   w = '{A_NONE,       C_ALWAYS,    U_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/mcpr_ram.sv
`timescale 1ns / 1ps

module mcpr_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mcpr_useq.sv
`timescale 1ns / 1ps

module mcpr_useq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mcpr_pkg::cond_flags_t    flags,
    output mcpr_pkg::ctrl_t          ctrl
);

    import mcpr_pkg::*;

    ustep_t upc_reg;
    ustep_t upc_next;
    logic   hit;

    // Control word of the current step
    always_comb
    begin
        ctrl = ucode(upc_reg);
    end

    // Condition select and next step
    always_comb
    begin
        case (ctrl.cond)
            C_ALWAYS:    hit = 1'b1;
            C_NEVER:     hit = 1'b0;
            C_NO_IN:     hit = flags.no_in;
            C_FAULT:     hit = flags.fault;
            C_SCAN_GE_N: hit = flags.scan_ge_n;
            C_SLOT_FREE: hit = flags.slot_free;
            C_NOT_LAST:  hit = flags.not_last;
            C_VICTIM:    hit = flags.victim;
            C_OUT_BUSY:  hit = flags.out_busy;
            default:     hit = 1'b1;
        endcase
        upc_next = hit ? ctrl.target : ustep_t'(4'(upc_reg) + 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: rtl/modified_clock_page_replacer_unit.sv
`timescale 1ns / 1ps

// Enhanced second-chance page replacer.
// Input channel (in_valid/in_ready): one item is either an access to a slot
// (kind 0) or a page fault (kind 1). Output channel (out_valid/out_ready):
// one result per item, in order. Config channel (cfg_valid/cfg_ready/cfg_data)
// writes ws_size; write it only while the block is idle.
// Steps: an accepted access reads its slot flags, updates them and then presents
// its result. A fault first loads the hand, then reduces it below the active
// size by repeated subtracts of the size, then walks for a free slot. With the
// set full it runs the clock, reading the flag RAM, evaluating and advancing for
// each slot passed, up to 4 passes over the active slots, then reads and swaps
// the victim page. Items are handled one at a time; the flag and page memories
// are single ported and set the per-slot pace.
// A new item is taken as soon as the previous result sits in the output
// register; a stalled receiver holds that result and stops the sequencer
// only when the next result is ready to go out.
// Reset empties the working set, puts the hand at slot 0 and ws_size at 64.
module modified_clock_page_replacer_unit #(
    parameter int SET_DEPTH        = 64,
    parameter int PAGE_NUMBER_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcpr_pkg::WS_BITS-1:0]        cfg_data,
    // input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [PAGE_NUMBER_BITS-1:0]         fault_page,
    input  logic [mcpr_pkg::SLOT_BITS-1:0]      access_slot,
    input  logic                                is_write,
    // result items
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mcpr_pkg::OUTCOME_BITS-1:0]   outcome,
    output logic [mcpr_pkg::SLOT_BITS-1:0]      slot,
    output logic [PAGE_NUMBER_BITS-1:0]         victim_page,
    output logic                                victim_dirty
);

    import mcpr_pkg::*;

    localparam int IW = $clog2(SET_DEPTH);
    localparam int CW = $clog2(SET_DEPTH + 1);

    ctrl_t       ctrl;
    cond_flags_t flags;

    // Control state
    logic [WS_BITS-1:0]   ws_size_reg;
    logic [SET_DEPTH-1:0] valid_reg,  valid_next;
    logic [IW-1:0]        hand_reg,   hand_next;
    logic [IW-1:0]        scan_reg,   scan_next;
    logic [IW-1:0]        count_reg,  count_next;
    logic [1:0]           pass_reg,   pass_next;
    logic                 out_valid_reg, out_valid_next;

    // Item and result payload
    logic                          kind_reg,   kind_next;
    logic [PAGE_NUMBER_BITS-1:0]   page_reg,   page_next;
    logic [SLOT_BITS-1:0]          aslot_reg,  aslot_next;
    logic                          wr_reg,     wr_next;
    logic                          dirty_reg,  dirty_next;
    logic [OUTCOME_BITS-1:0]       res_outcome_reg, res_outcome_next;
    logic [SLOT_BITS-1:0]          res_slot_reg,    res_slot_next;
    logic [PAGE_NUMBER_BITS-1:0]   res_victim_reg,  res_victim_next;
    logic                          res_dirty_reg,   res_dirty_next;
    logic [OUTCOME_BITS-1:0]       out_outcome_reg, out_outcome_next;
    logic [SLOT_BITS-1:0]          out_slot_reg,    out_slot_next;
    logic [PAGE_NUMBER_BITS-1:0]   out_victim_reg,  out_victim_next;
    logic                          out_dirty_reg,   out_dirty_next;

    // Memory ports
    logic                          f_we, f_re;
    logic [IW-1:0]                 f_addr;
    logic [1:0]                    f_wdata, f_rdata;   // {used, modified}
    logic                          p_we, p_re;
    logic [PAGE_NUMBER_BITS-1:0]   p_rdata;

    // Derived values
    logic [CW-1:0] n_eff;
    logic [IW-1:0] aslot_idx;
    logic [IW-1:0] scan_inc;
    logic          count_last;
    logic          acc_bad;
    logic          out_busy;

    mcpr_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    mcpr_ram #(
        .WIDTH (2),
        .DEPTH (SET_DEPTH)
    ) u_flag_ram (
        .clk   (clk),
        .we    (f_we),
        .re    (f_re),
        .addr  (f_addr),
        .wdata (f_wdata),
        .rdata (f_rdata)
    );

    mcpr_ram #(
        .WIDTH (PAGE_NUMBER_BITS),
        .DEPTH (SET_DEPTH)
    ) u_page_ram (
        .clk   (clk),
        .we    (p_we),
        .re    (p_re),
        .addr  (scan_reg),
        .wdata (page_reg),
        .rdata (p_rdata)
    );

    // Active size, clamped to 1..SET_DEPTH
    always_comb
    begin
        if (ws_size_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(ws_size_reg) > SET_DEPTH)
        begin
            n_eff = CW'(SET_DEPTH);
        end
        else
        begin
            n_eff = CW'(ws_size_reg);
        end
    end

    assign aslot_idx  = IW'(aslot_reg);
    assign scan_inc   = (32'(scan_reg) + 32'd1 == 32'(n_eff)) ? '0 : scan_reg + IW'(1);
    assign count_last = (32'(count_reg) + 32'd1 == 32'(n_eff));
    assign acc_bad    = (32'(aslot_reg) >= 32'(n_eff)) || !valid_reg[aslot_idx];
    assign out_busy   = out_valid_reg && !out_ready;

    // Branch conditions for the sequencer
    always_comb
    begin
        flags.no_in     = !in_valid;
        flags.fault     = kind_reg;
        flags.scan_ge_n = (32'(scan_reg) >= 32'(n_eff));
        flags.slot_free = !valid_reg[scan_reg];
        flags.not_last  = !count_last;
        flags.victim    = pass_reg[0] ? !f_rdata[1] : (!f_rdata[1] && !f_rdata[0]);
        flags.out_busy  = out_busy;
    end

    // Datapath driven by the current action
    always_comb
    begin
        valid_next       = valid_reg;
        hand_next        = hand_reg;
        scan_next        = scan_reg;
        count_next       = count_reg;
        pass_next        = pass_reg;
        kind_next        = kind_reg;
        page_next        = page_reg;
        aslot_next       = aslot_reg;
        wr_next          = wr_reg;
        dirty_next       = dirty_reg;
        res_outcome_next = res_outcome_reg;
        res_slot_next    = res_slot_reg;
        res_victim_next  = res_victim_reg;
        res_dirty_next   = res_dirty_reg;
        f_we             = 1'b0;
        f_re             = 1'b0;
        f_addr           = scan_reg;
        f_wdata          = 2'b00;
        p_we             = 1'b0;
        p_re             = 1'b0;
        case (ctrl.act)
            A_LOAD:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    page_next  = fault_page;
                    aslot_next = access_slot;
                    wr_next    = is_write;
                end
            end
            A_FRD_ASLOT:
            begin
                f_re   = 1'b1;
                f_addr = aslot_idx;
            end
            A_ACC_UPD:
            begin
                f_addr          = aslot_idx;
                res_slot_next   = aslot_reg;
                res_victim_next = '0;
                res_dirty_next  = 1'b0;
                if (acc_bad)
                begin
                    res_outcome_next = OUT_IGNORED;
                end
                else
                begin
                    res_outcome_next = OUT_ACCESS;
                    f_we             = 1'b1;
                    f_wdata          = {1'b1, f_rdata[0] | wr_reg};
                end
            end
            A_SCAN_HAND:
            begin
                scan_next  = hand_reg;
                count_next = '0;
                pass_next  = 2'd0;
            end
            A_SCAN_SUB:
            begin
                // hand modulo active size, one subtract per step
                if (flags.scan_ge_n)
                begin
                    scan_next = scan_reg - IW'(n_eff);
                end
            end
            A_PLACE_STEP:
            begin
                if (flags.slot_free)
                begin
                    p_we                 = 1'b1;
                    f_we                 = 1'b1;
                    f_wdata              = 2'b00;
                    valid_next[scan_reg] = 1'b1;
                    hand_next            = scan_inc;
                    res_outcome_next     = OUT_PLACED;
                    res_slot_next        = SLOT_BITS'(scan_reg);
                    res_victim_next      = '0;
                    res_dirty_next       = 1'b0;
                end
            end
            A_ADVANCE:
            begin
                scan_next = scan_inc;
                if (count_last)
                begin
                    count_next = '0;
                    pass_next  = pass_reg + 2'd1;
                end
                else
                begin
                    count_next = count_reg + IW'(1);
                end
            end
            A_REP_INIT:
            begin
                count_next = '0;
                pass_next  = 2'd0;
            end
            A_FRD_SCAN:
            begin
                f_re = 1'b1;
            end
            A_CLEAR_USED:
            begin
                // second-chance pass strips the used bit of slots it passes
                dirty_next = f_rdata[0];
                if (pass_reg[0] && f_rdata[1])
                begin
                    f_we    = 1'b1;
                    f_wdata = {1'b0, f_rdata[0]};
                end
            end
            A_PRD_SCAN:
            begin
                p_re = 1'b1;
            end
            A_REPLACE:
            begin
                p_we             = 1'b1;
                f_we             = 1'b1;
                f_wdata          = 2'b00;
                hand_next        = scan_inc;
                res_outcome_next = OUT_REPLACED;
                res_slot_next    = SLOT_BITS'(scan_reg);
                res_victim_next  = p_rdata;
                res_dirty_next   = dirty_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_outcome_next = out_outcome_reg;
        out_slot_next    = out_slot_reg;
        out_victim_next  = out_victim_reg;
        out_dirty_next   = out_dirty_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.act == A_EMIT && !out_busy)
        begin
            out_valid_next   = 1'b1;
            out_outcome_next = res_outcome_reg;
            out_slot_next    = res_slot_reg;
            out_victim_next  = res_victim_reg;
            out_dirty_next   = res_dirty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_size_reg   <= WS_RESET;
            valid_reg     <= '0;
            hand_reg      <= '0;
            scan_reg      <= '0;
            count_reg     <= '0;
            pass_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                ws_size_reg <= cfg_data;
            end
            valid_reg     <= valid_next;
            hand_reg      <= hand_next;
            scan_reg      <= scan_next;
            count_reg     <= count_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        page_reg        <= page_next;
        aslot_reg       <= aslot_next;
        wr_reg          <= wr_next;
        dirty_reg       <= dirty_next;
        res_outcome_reg <= res_outcome_next;
        res_slot_reg    <= res_slot_next;
        res_victim_reg  <= res_victim_next;
        res_dirty_reg   <= res_dirty_next;
        out_outcome_reg <= out_outcome_next;
        out_slot_reg    <= out_slot_next;
        out_victim_reg  <= out_victim_next;
        out_dirty_reg   <= out_dirty_next;
    end

    assign cfg_ready    = 1'b1;
    assign in_ready     = (ctrl.act == A_LOAD);
    assign out_valid    = out_valid_reg;
    assign outcome      = out_outcome_reg;
    assign slot         = out_slot_reg;
    assign victim_page  = out_victim_reg;
    assign victim_dirty = out_dirty_reg;

    // The free-slot walk only visits active slots
    a_place_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == A_PLACE_STEP) |-> (32'(scan_reg) < 32'(n_eff)))
        else $error("placement walk left the active slots");

    // The clock never advances off the last slot of its final pass
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == A_ADVANCE && pass_reg == 2'd3) |-> !count_last)
        else $error("clock ran past its last pass");

    // A victim is always an occupied slot
    a_victim_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == A_REPLACE) |-> valid_reg[scan_reg])
        else $error("replacement chose an empty slot");

    // A placement marks its slot occupied on the next cycle
    a_place_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == A_PLACE_STEP && flags.slot_free) |=> valid_reg[$past(scan_reg)])
        else $error("placed slot not marked valid");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import mcpr_pkg::*;

    localparam int          DEPTH       = 64;
    localparam int          PAGE_BITS   = 20;
    localparam logic        KIND_ACCESS = 1'b0;
    localparam logic        KIND_FAULT  = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 5000000;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [OUTCOME_BITS-1:0] outcome;
        logic [SLOT_BITS-1:0]    slot;
        logic [PAGE_BITS-1:0]    victim_page;
        logic                    victim_dirty;
    } page_result_t;

    // Scoreboard: mirror of the working set plus the queue of pending results
    class replacer_scoreboard;
        bit                 valid_q[DEPTH];
        bit [PAGE_BITS-1:0] page_q[DEPTH];
        bit                 used_q[DEPTH];
        bit                 mod_q[DEPTH];
        int unsigned        hand;
        bit [WS_BITS-1:0]   ws_size;
        page_result_t       pending_q[$];
        int                 errors;

        function new();
            ws_size = WS_RESET;
            hand    = 0;
            errors  = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_q[i] = 1'b0;
                page_q[i]  = '0;
                used_q[i]  = 1'b0;
                mod_q[i]   = 1'b0;
            end
        endfunction

        // ws_size clamped to 1..DEPTH
        function int unsigned active_slots();
            if (ws_size == 0)
                return 1;
            if (ws_size > DEPTH)
                return DEPTH;
            return 32'(ws_size);
        endfunction

        function void set_size(bit [WS_BITS-1:0] v);
            ws_size = v;
        endfunction

        // Work out the result of one accepted item and queue it
        function void note_item(bit k, bit [PAGE_BITS-1:0] pg, bit [SLOT_BITS-1:0] aslot,
                                bit wr);
            int unsigned  n, h, idx, s, pass;
            bit           found;
            page_result_t r;
            n = active_slots();
            r = '0;
            if (k == KIND_ACCESS)
            begin
                r.slot = aslot;
                if (aslot >= n || !valid_q[aslot])
                    r.outcome = OUT_IGNORED;
                else
                begin
                    used_q[aslot] = 1'b1;
                    if (wr)
                        mod_q[aslot] = 1'b1;
                    r.outcome = OUT_ACCESS;
                end
                pending_q.push_back(r);
                return;
            end
            h = hand % n;
            // placement into the first free slot from the hand
            for (int i = 0; i < n; i++)
            begin
                idx = (h + i) % n;
                if (!valid_q[idx])
                begin
                    valid_q[idx] = 1'b1;
                    page_q[idx]  = pg;
                    used_q[idx]  = 1'b0;
                    mod_q[idx]   = 1'b0;
                    hand         = (idx + 1) % n;
                    r.outcome    = OUT_PLACED;
                    r.slot       = SLOT_BITS'(idx);
                    pending_q.push_back(r);
                    return;
                end
            end
            // modified clock: even passes want clean+unused, odd passes clear used
            idx   = h;
            found = 1'b0;
            for (pass = 0; pass < 4 && !found; pass++)
            begin
                for (int i = 0; i < n && !found; i++)
                begin
                    s = (h + i) % n;
                    if (pass % 2 == 0)
                    begin
                        if (!used_q[s] && !mod_q[s])
                        begin
                            idx   = s;
                            found = 1'b1;
                        end
                    end
                    else if (!used_q[s])
                    begin
                        idx   = s;
                        found = 1'b1;
                    end
                    else
                        used_q[s] = 1'b0;
                end
            end
            r.outcome      = OUT_REPLACED;
            r.slot         = SLOT_BITS'(idx);
            r.victim_page  = page_q[idx];
            r.victim_dirty = mod_q[idx];
            page_q[idx]    = pg;
            used_q[idx]    = 1'b0;
            mod_q[idx]     = 1'b0;
            hand           = (idx + 1) % n;
            pending_q.push_back(r);
        endfunction

        // Compare one result with the oldest pending one
        function void check_result(page_result_t got);
            page_result_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: outcome %0d slot %0d page %h dirty %0d",
                             got.outcome, got.slot, got.victim_page, got.victim_dirty);
                return;
            end
            want = pending_q.pop_front();
            if (got.outcome !== want.outcome || got.slot !== want.slot ||
                got.victim_page !== want.victim_page ||
                got.victim_dirty !== want.victim_dirty)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: outcome %0d/%0d slot %0d/%0d page %h/%h dirty %0d/%0d",
                             got.outcome, want.outcome, got.slot, want.slot,
                             got.victim_page, want.victim_page,
                             got.victim_dirty, want.victim_dirty);
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [WS_BITS-1:0]      cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    kind;
    logic [PAGE_BITS-1:0]    fault_page;
    logic [SLOT_BITS-1:0]    access_slot;
    logic                    is_write;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [OUTCOME_BITS-1:0] outcome;
    logic [SLOT_BITS-1:0]    slot;
    logic [PAGE_BITS-1:0]    victim_page;
    logic                    victim_dirty;

    replacer_scoreboard sb;
    bit                 burst_mode;
    int unsigned        ready_hold = 0;
    int unsigned        stall_roll;
    int unsigned        cycle_count = 0;

    modified_clock_page_replacer_unit #(
        .SET_DEPTH        (DEPTH),
        .PAGE_NUMBER_BITS (PAGE_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .fault_page   (fault_page),
        .access_slot  (access_slot),
        .is_write     (is_write),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .outcome      (outcome),
        .slot         (slot),
        .victim_page  (victim_page),
        .victim_dirty (victim_dirty)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Receiver stalls: mostly short, sometimes long, none in burst stretches
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (burst_mode)
            out_ready <= 1'b1;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 55)
            begin
                out_ready  <= 1'b1;
                ready_hold <= $urandom_range(0, 4);
            end
            else if (stall_roll < 93)
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end
            else
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(10, 50);
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({outcome, slot, victim_page, victim_dirty});
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one item, hold it until taken, then maybe idle
    task automatic send_item(logic k, logic [PAGE_BITS-1:0] pg, logic [SLOT_BITS-1:0] aslot,
                             logic wr);
        int unsigned gap;
        in_valid    <= 1'b1;
        kind        <= k;
        fault_page  <= pg;
        access_slot <= aslot;
        is_write    <= wr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(k, pg, aslot, wr);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain all pending results, then write ws_size
    task automatic write_size(logic [WS_BITS-1:0] v);
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_size(v);
    endtask

    // Random item shaped to the current active size
    task automatic send_random_item();
        int unsigned      n;
        logic [SLOT_BITS-1:0] aslot;
        n = sb.active_slots();
        if ($urandom_range(0, 99) < 85)
            aslot = SLOT_BITS'($urandom_range(0, n - 1));
        else
            aslot = SLOT_BITS'($urandom_range(0, DEPTH - 1));
        if ($urandom_range(0, 99) < 35)
            send_item(KIND_FAULT, PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1)),
                      SLOT_BITS'($urandom_range(0, DEPTH - 1)), 1'($urandom_range(0, 1)));
        else
            send_item(KIND_ACCESS, PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1)),
                      aslot, 1'($urandom_range(0, 1)));
    endtask

    int unsigned phase_size[10]  = '{1, 64, 3, 127, 0, 2, 40, 64, 0, 0};
    int unsigned phase_items[10] = '{60, 200, 80, 150, 40, 60, 120, 150, 80, 80};

    initial
    begin
        sb          = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        kind        = KIND_ACCESS;
        fault_page  = '0;
        access_slot = '0;
        is_write    = 1'b0;
        burst_mode  = 1'b0;
        phase_size[8] = $urandom_range(0, 127);
        phase_size[9] = $urandom_range(0, 127);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty set at reset size: accesses ignored, faults fill from slot 0, later accesses hit
        send_item(KIND_ACCESS, 20'h00000, 6'd0, 1'b0);
        send_item(KIND_ACCESS, 20'hFFFFF, 6'd63, 1'b1);
        send_item(KIND_FAULT, 20'h00000, 6'd63, 1'b1);
        send_item(KIND_FAULT, 20'hFFFFF, 6'd0, 1'b0);
        send_item(KIND_ACCESS, 20'h00000, 6'd0, 1'b1);
        send_item(KIND_ACCESS, 20'h00000, 6'd1, 1'b0);

        // Two slots, full: victims found on pass three, pass four, pass one
        write_size(7'd2);
        send_item(KIND_FAULT, 20'h12345, 6'd5, 1'b0);
        send_item(KIND_ACCESS, 20'h00000, 6'd0, 1'b1);
        send_item(KIND_ACCESS, 20'h00000, 6'd1, 1'b1);
        send_item(KIND_FAULT, 20'hABCDE, 6'd0, 1'b1);
        send_item(KIND_FAULT, 20'h80001, 6'd0, 1'b0);
        send_item(KIND_ACCESS, 20'h00000, 6'd2, 1'b1);

        // Size zero acts as one; slot 1 falls outside the active set
        write_size(7'd0);
        send_item(KIND_ACCESS, 20'h00000, 6'd1, 1'b1);
        send_item(KIND_FAULT, 20'h55555, 6'd0, 1'b0);
        send_item(KIND_ACCESS, 20'h00000, 6'd0, 1'b1);
        send_item(KIND_FAULT, 20'hAAAAA, 6'd0, 1'b0);

        // Oversize clamps to the full set; old slots keep their pages
        write_size(7'd127);
        send_item(KIND_FAULT, 20'h0F0F0, 6'd0, 1'b0);
        send_item(KIND_ACCESS, 20'h00000, 6'd1, 1'b0);
        send_item(KIND_ACCESS, 20'h00000, 6'd2, 1'b1);
        send_item(KIND_ACCESS, 20'h00000, 6'd3, 1'b1);

        // Random phases over a range of sizes
        for (int p = 0; p < 10; p++)
        begin
            write_size(WS_BITS'(phase_size[p]));
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_items[p]; i++)
                send_random_item();
        end

        in_valid   <= 1'b0;
        burst_mode = 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
